// ===== hdl/bsc_pkg.sv =====
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared types, constants and character tables for the base64 stream codec.
// ----------------------------------------------------------------------------
package bsc_pkg;

    localparam int JOB_SLOTS   = 4;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    typedef enum logic {
        CFG_MODE  = 1'b0,
        CFG_LIMIT = 1'b1
    } cfg_index_t;

    typedef enum logic {
        MODE_ENCODE = 1'b0,
        MODE_DECODE = 1'b1
    } mode_t;

    // Work handed from the front end to the back end for one input item.
    typedef struct packed {
        logic [JOB_SLOTS-1:0][7:0] data_bytes;
        logic [2:0]                n_data;
        logic                      term;
    } job_t;

    function automatic logic [7:0] enc_char(input logic [5:0] s);
        logic [7:0] c;
        c = {2'b00, s};
        if (s < 6'd26) begin
            return c + 8'd65;
        end else if (s < 6'd52) begin
            return c + 8'd71;
        end else if (s < 6'd62) begin
            return c - 8'd4;
        end else if (s == 6'd62) begin
            return 8'h2B;
        end else begin
            return 8'h2F;
        end
    endfunction

    // bit 6 set: not an alphabet character
    function automatic logic [6:0] dec_sextet(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h40;
        if (c >= 8'h41 && c <= 8'h5A) begin
            v = c - 8'd65;
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            v = c - 8'd71;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            v = c + 8'd4;
        end else if (c == 8'h2B) begin
            v = 8'd62;
        end else if (c == 8'h2F) begin
            v = 8'd63;
        end
        return v[6:0];
    endfunction

endpackage

// ===== hdl/base64_stream_codec.sv =====
// ----------------------------------------------------------------------------
// base64_stream_codec
// Base64 encoder/decoder, one message at a time, with output limit and a
// length-carrying terminator transaction at the end of every message.
// ----------------------------------------------------------------------------
// Path: each accepted item passes the job queue and the back-end job register before the result register.
// The back end spends a step on every job plus one on every further result, so the rate
//   of encode and decode is set by the single result port. Two-entry job queue absorbs
//   result stalls, so a new item can be taken before the one ahead of it is through.
// Reset: synchronous, active low; encode mode, limit 65535, queue empty.
module base64_stream_codec (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        s_in_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_out_end,
    output logic [15:0] m_out_length
);
    import bsc_pkg::*;

    logic        mode_reg;
    logic [15:0] limit_reg;
    logic        cfg_wr, clear;
    logic        q_push, q_pop, q_full, q_empty;
    job_t        push_job, pop_job;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign clear     = cfg_wr && (cfg_index == CFG_MODE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_ENCODE;
            limit_reg <= 16'hFFFF;
        end else if (cfg_wr) begin
            unique case (cfg_index)
                CFG_MODE:  mode_reg  <= cfg_data[0];
                CFG_LIMIT: limit_reg <= cfg_data;
                default:   limit_reg <= limit_reg;
            endcase
        end
    end

    bsc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .clear     (clear),
        .mode      (mode_reg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_in_byte (s_in_byte),
        .s_in_last (s_in_last),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_job     (push_job)
    );

    bsc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .pop_job  (pop_job),
        .empty    (q_empty)
    );

    bsc_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .clear        (clear),
        .out_limit    (limit_reg),
        .q_empty      (q_empty),
        .q_job        (pop_job),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_out_end    (m_out_end),
        .m_out_length (m_out_length)
    );

endmodule

// ===== hdl/bsc_front.sv =====
// ----------------------------------------------------------------------------
// bsc_front
// Accepts input transactions, tracks the base64 group and turns each item
// into a job of up to four data bytes plus an optional terminator.
// ----------------------------------------------------------------------------
module bsc_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          clear,
    input  logic          mode,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [7:0]    s_in_byte,
    input  logic          s_in_last,
    input  logic          q_full,
    output logic          q_push,
    output bsc_pkg::job_t q_job
);
    import bsc_pkg::*;

    logic [17:0] hold_reg,  hold_next;
    logic [1:0]  phase_reg, phase_next;
    logic        skip_reg,  skip_next;

    logic [23:0] w;
    logic [17:0] nh;
    logic [1:0]  np;
    logic [6:0]  sx;
    logic        accept;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign q_push  = accept;

    always_comb begin
        hold_next  = hold_reg;
        phase_next = phase_reg;
        skip_next  = skip_reg;
        q_job      = '0;
        w          = '0;
        nh         = '0;
        np         = '0;
        sx         = dec_sextet(s_in_byte);
        if (mode == MODE_ENCODE) begin
            if (phase_reg >= 2'd2) begin
                w = {hold_reg[15:0], s_in_byte};
                q_job.data_bytes[0] = enc_char(w[23:18]);
                q_job.data_bytes[1] = enc_char(w[17:12]);
                q_job.data_bytes[2] = enc_char(w[11:6]);
                q_job.data_bytes[3] = enc_char(w[5:0]);
                q_job.n_data = 3'd4;
                hold_next  = '0;
                phase_next = '0;
            end else begin
                nh = {2'b00, hold_reg[7:0], s_in_byte};
                np = phase_reg + 2'd1;
                hold_next  = nh;
                phase_next = np;
                if (s_in_last) begin
                    if (np == 2'd1) begin
                        q_job.data_bytes[0] = enc_char(nh[7:2]);
                        q_job.data_bytes[1] = enc_char({nh[1:0], 4'b0000});
                        q_job.data_bytes[2] = PAD_CHAR;
                        q_job.data_bytes[3] = PAD_CHAR;
                    end else begin
                        q_job.data_bytes[0] = enc_char(nh[15:10]);
                        q_job.data_bytes[1] = enc_char(nh[9:4]);
                        q_job.data_bytes[2] = enc_char({nh[3:0], 2'b00});
                        q_job.data_bytes[3] = PAD_CHAR;
                    end
                    q_job.n_data = 3'd4;
                end
            end
        end else if (!skip_reg) begin
            if (sx[6]) begin
                // end of data: flush what the group holds
                nh = hold_reg;
                np = phase_reg;
            end else if (phase_reg == 2'd3) begin
                w = {hold_reg, sx[5:0]};
                q_job.data_bytes[0] = w[23:16];
                q_job.data_bytes[1] = w[15:8];
                q_job.data_bytes[2] = w[7:0];
                q_job.n_data = 3'd3;
                hold_next  = '0;
                phase_next = '0;
            end else begin
                nh = {hold_reg[11:0], sx[5:0]};
                np = phase_reg + 2'd1;
                hold_next  = nh;
                phase_next = np;
            end
            if (sx[6] || (s_in_last && phase_reg != 2'd3)) begin
                if (np == 2'd2) begin
                    q_job.data_bytes[0] = nh[11:4];
                    q_job.n_data = 3'd1;
                end else if (np == 2'd3) begin
                    q_job.data_bytes[0] = nh[17:10];
                    q_job.data_bytes[1] = nh[9:2];
                    q_job.n_data = 3'd2;
                end
                hold_next  = '0;
                phase_next = '0;
                skip_next  = 1'b1;
            end
        end
        if (s_in_last) begin
            q_job.term = 1'b1;
            hold_next  = '0;
            phase_next = '0;
            skip_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            hold_reg  <= '0;
            phase_reg <= '0;
            skip_reg  <= 1'b0;
        end else if (accept) begin
            hold_reg  <= hold_next;
            phase_reg <= phase_next;
            skip_reg  <= skip_next;
        end
    end

endmodule

// ===== hdl/bsc_queue.sv =====
// ----------------------------------------------------------------------------
// bsc_queue
// Small job queue between front end and back end.
// ----------------------------------------------------------------------------
module bsc_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  bsc_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output bsc_pkg::job_t pop_job,
    output logic          empty
);
    import bsc_pkg::*;

    job_t               entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QFILL_W-1:0] fill_reg;

    assign full    = (fill_reg == QFILL_W'(QUEUE_DEPTH));
    assign empty   = (fill_reg == '0);
    assign pop_job = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + 1'b1;
            end else if (pop && !push) begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

// ===== hdl/bsc_back.sv =====
// ----------------------------------------------------------------------------
// bsc_back
// Plays out one job at a time onto the result channel, one transaction per cycle
// while not stalled, applying the output limit and closing messages with a terminator.
// ----------------------------------------------------------------------------
module bsc_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          clear,
    input  logic [15:0]   out_limit,
    input  logic          q_empty,
    input  bsc_pkg::job_t q_job,
    output logic          q_pop,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [7:0]    m_out_byte,
    output logic          m_out_end,
    output logic [15:0]   m_out_length
);
    import bsc_pkg::*;

    job_t        job_reg;
    logic        job_valid_reg;
    logic [2:0]  idx_reg;
    logic [15:0] count_reg;
    logic        m_valid_reg;
    logic [7:0]  m_byte_reg;
    logic        m_end_reg;
    logic [15:0] m_length_reg;

    logic        out_free, step, has_data, more_data, retire, emit_data, emit_term;
    logic [2:0]  idx_inc;
    logic [16:0] count_inc;

    always_comb begin
        out_free  = !m_valid_reg || m_ready;
        step      = job_valid_reg && out_free;
        idx_inc   = idx_reg + 3'd1;
        count_inc = {1'b0, count_reg} + 17'd1;
        has_data  = (idx_reg < job_reg.n_data) && (count_reg < out_limit);
        more_data = (idx_inc < job_reg.n_data) && (count_inc < {1'b0, out_limit});
        retire    = step && (has_data ? (!more_data && !job_reg.term) : 1'b1);
        emit_data = step && has_data;
        emit_term = step && !has_data && job_reg.term;
        q_pop     = !q_empty && (!job_valid_reg || retire);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end else if (q_pop) begin
            job_valid_reg <= 1'b1;
            idx_reg       <= '0;
        end else if (retire) begin
            job_valid_reg <= 1'b0;
        end else if (emit_data) begin
            idx_reg <= idx_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            job_reg <= q_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clear || emit_term) begin
            count_reg <= '0;
        end else if (emit_data) begin
            count_reg <= count_inc[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit_data || emit_term) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_data) begin
            m_byte_reg   <= job_reg.data_bytes[idx_reg[1:0]];
            m_end_reg    <= 1'b0;
            m_length_reg <= '0;
        end else if (emit_term) begin
            m_byte_reg   <= '0;
            m_end_reg    <= 1'b1;
            m_length_reg <= count_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_byte   = m_byte_reg;
    assign m_out_end    = m_end_reg;
    assign m_out_length = m_length_reg;

endmodule

// ===== tb/base64_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// base64_checker
// Watches the config, input and result channels of the base64 codec. It keeps
// its own copy of the codec state, works out the expected result transactions
// for every accepted input transaction and compares every accepted result,
// field by field, with the oldest expected one.
// ----------------------------------------------------------------------------
module base64_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        s_in_last,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_out_byte,
    input  logic        m_out_end,
    input  logic [15:0] m_out_length,
    output int          fail_count,
    output int          pending
);
    import bsc_pkg::*;

    typedef struct packed {
        logic [7:0]  data;
        logic        term;
        logic [15:0] length;
    } codec_result_t;

    codec_result_t expected_q[$];

    mode_t       cur_mode;
    logic [15:0] limit;
    logic [17:0] hold;
    logic [1:0]  phase;
    logic [15:0] emitted;
    logic        skipping;
    int          mismatches = 0;

    assign fail_count = mismatches;

    task automatic report(input string msg);
        mismatches++;
        if (mismatches <= 50) begin
            $display("%0t: mismatch: %s", $time, msg);
        end
    endtask

    function automatic logic [7:0] symbol_of(input logic [5:0] s);
        if (s < 6'd26) begin
            return 8'h41 + {2'b00, s};
        end
        if (s < 6'd52) begin
            return 8'h61 + {2'b00, s} - 8'd26;
        end
        if (s < 6'd62) begin
            return 8'h30 + {2'b00, s} - 8'd52;
        end
        return (s == 6'd62) ? 8'h2B : 8'h2F;
    endfunction

    // -1 for anything outside the alphabet, padding included
    function automatic int value_of(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A) begin
            return int'(c) - 'h41;
        end
        if (c >= 8'h61 && c <= 8'h7A) begin
            return int'(c) - 'h61 + 26;
        end
        if (c >= 8'h30 && c <= 8'h39) begin
            return int'(c) - 'h30 + 52;
        end
        if (c == 8'h2B) begin
            return 62;
        end
        if (c == 8'h2F) begin
            return 63;
        end
        return -1;
    endfunction

    task automatic clear_message();
        hold     = '0;
        phase    = '0;
        emitted  = '0;
        skipping = 1'b0;
    endtask

    task automatic put_data(input logic [7:0] v);
        if (emitted < limit) begin
            expected_q.push_back('{data: v, term: 1'b0, length: 16'd0});
            emitted++;
        end
    endtask

    task automatic encode_byte(input logic [7:0] b, input logic last);
        logic [23:0] w;
        if (phase >= 2'd2) begin
            w = {hold[15:0], b};
            put_data(symbol_of(w[23:18]));
            put_data(symbol_of(w[17:12]));
            put_data(symbol_of(w[11:6]));
            put_data(symbol_of(w[5:0]));
            hold  = '0;
            phase = '0;
        end else begin
            hold  = {2'b00, hold[7:0], b};
            phase = phase + 2'd1;
        end
        if (last) begin
            if (phase == 2'd1) begin
                put_data(symbol_of(hold[7:2]));
                put_data(symbol_of({hold[1:0], 4'b0000}));
                put_data(PAD_CHAR);
                put_data(PAD_CHAR);
            end else if (phase == 2'd2) begin
                put_data(symbol_of(hold[15:10]));
                put_data(symbol_of(hold[9:4]));
                put_data(symbol_of({hold[3:0], 2'b00}));
                put_data(PAD_CHAR);
            end
        end
    endtask

    // end of text: flush a partial group, ignore the rest of the message
    task automatic end_of_text();
        if (phase == 2'd2) begin
            put_data(hold[11:4]);
        end else if (phase == 2'd3) begin
            put_data(hold[17:10]);
            put_data(hold[9:2]);
        end
        hold     = '0;
        phase    = '0;
        skipping = 1'b1;
    endtask

    task automatic decode_char(input logic [7:0] c, input logic last);
        int          v;
        logic [23:0] w;
        if (skipping) begin
            return;
        end
        v = value_of(c);
        if (v < 0) begin
            end_of_text();
            return;
        end
        if (phase == 2'd3) begin
            w = {hold, v[5:0]};
            put_data(w[23:16]);
            put_data(w[15:8]);
            put_data(w[7:0]);
            hold  = '0;
            phase = '0;
        end else begin
            hold  = {hold[11:0], v[5:0]};
            phase = phase + 2'd1;
        end
        if (last) begin
            end_of_text();
        end
    endtask

    task automatic predict_item(input logic [7:0] b, input logic last);
        if (cur_mode == MODE_ENCODE) begin
            encode_byte(b, last);
        end else begin
            decode_char(b, last);
        end
        if (last) begin
            expected_q.push_back('{data: 8'd0, term: 1'b1, length: emitted});
            clear_message();
        end
    endtask

    task automatic check_result();
        codec_result_t want;
        if (expected_q.size() == 0) begin
            report($sformatf("unexpected result byte=%02h end=%0b length=%0d",
                             m_out_byte, m_out_end, m_out_length));
            return;
        end
        want = expected_q.pop_front();
        if (m_out_byte !== want.data) begin
            report($sformatf("out_byte %02h, expected %02h", m_out_byte, want.data));
        end
        if (m_out_end !== want.term) begin
            report($sformatf("out_end %0b, expected %0b", m_out_end, want.term));
        end
        if (m_out_length !== want.length) begin
            report($sformatf("out_length %0d, expected %0d", m_out_length, want.length));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            expected_q.delete();
            cur_mode = MODE_ENCODE;
            limit    = 16'hFFFF;
            clear_message();
        end else begin
            if (m_valid && m_ready) begin
                check_result();
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_MODE) begin
                    cur_mode = mode_t'(cfg_data[0]);
                    clear_message();
                end else begin
                    limit = cfg_data;
                end
            end
            if (s_valid && s_ready) begin
                predict_item(s_in_byte, s_in_last);
            end
        end
        pending <= expected_q.size();
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the base64 stream codec: a short directed run over padding,
// end of text, output limit and mode switch cases, then random encode and
// decode messages under random settings, with random gaps on both channels.
// ----------------------------------------------------------------------------
module testbench;
    import bsc_pkg::*;

    localparam int RANDOM_ITEMS  = 350;
    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = 10;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [15:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_in_byte;
    logic        s_in_last;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_out_byte;
    logic        m_out_end;
    logic [15:0] m_out_length;
    int          fail_count;
    int          pending;

    string b64_symbols =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    mode_t tb_mode;
    bit    tx_steady;
    bit    rx_steady;
    int    long_holds_wanted;
    int    items_sent;

    base64_stream_codec dut (.*);

    base64_checker result_check (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic int pick_length();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    endfunction

    function automatic logic [15:0] pick_limit();
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'($urandom_range(1, 4));
            2: return 16'($urandom_range(5, 40));
            3: return 16'($urandom);
            default: return 16'hFFFF;
        endcase
    endfunction

    // result side: short random stalls, plus a long hold when asked for
    initial begin : result_sink
        int hold;
        int holds_done;
        hold       = 0;
        holds_done = 0;
        m_ready    = 1'b0;
        forever begin
            @(posedge aclk);
            if (holds_done != long_holds_wanted) begin
                holds_done = long_holds_wanted;
                hold       = LONG_HOLD;
            end else if (hold == 0 && !rx_steady && $urandom_range(0, 3) == 0) begin
                hold = pick_gap();
            end
            if (hold > 0) begin
                m_ready <= 1'b0;
                hold--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic cfg_write(input cfg_index_t idx, input logic [15:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_mode(input mode_t m);
        tb_mode = m;
        cfg_write(CFG_MODE, {15'd0, m});
    endtask

    // called in the step of the previous acceptance, so valid stays up on gap 0
    task automatic send_item(input logic [7:0] b, input logic last);
        int gap;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_in_byte <= b;
        s_in_last <= last;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    task automatic send_text(input string txt, input bit close);
        for (int i = 0; i < txt.len(); i++) begin
            send_item(txt[i], close && i == txt.len() - 1);
        end
    endtask

    // stop sending and wait for every expected result, then let the pipe settle
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic random_encode_message();
        int n;
        n = pick_length();
        for (int i = 0; i < n; i++) begin
            send_item(8'($urandom), i == n - 1);
        end
    endtask

    task automatic random_decode_message();
        logic [7:0] text[$];
        int         n;
        int         kind;
        n    = pick_length();
        kind = $urandom_range(0, 9);
        for (int i = 0; i < n; i++) begin
            text.push_back(b64_symbols[$urandom_range(0, 63)]);
        end
        if (kind < 6) begin
            while (text.size() % 4 != 0) begin
                text.push_back(PAD_CHAR);
            end
        end
        if (kind < 2 || kind == 7) begin
            repeat ($urandom_range(1, 3)) text.push_back(8'($urandom));
        end
        if (kind == 8) begin
            text.insert($urandom_range(0, text.size() - 1), 8'($urandom));
        end
        if (kind == 9) begin
            foreach (text[i]) begin
                text[i] = 8'($urandom);
            end
        end
        foreach (text[i]) begin
            send_item(text[i], i == text.size() - 1);
        end
    endtask

    task automatic directed_run();
        // encode: one-byte tail, two-byte tail, full group hitting '+' and '/'
        send_item(8'h00, 1'b1);
        send_item(8'hFF, 1'b0);
        send_item(8'hFF, 1'b1);
        send_item(8'hFB, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'hBF, 1'b1);
        // half-collected group, then abandoned by the mode switch
        send_item(8'h12, 1'b0);
        send_item(8'h34, 1'b0);
        drain();
        set_mode(MODE_DECODE);
        send_text("QQ==", 1'b1);
        send_text("QUI", 1'b1);
        send_text("Q", 1'b1);
        send_item(8'h00, 1'b0);
        send_item(8'h41, 1'b0);
        send_item(8'hFF, 1'b1);
        drain();
        cfg_write(CFG_LIMIT, 16'd0);
        send_text("TQ", 1'b1);
        drain();
        // limit lowered in the middle of a message
        cfg_write(CFG_LIMIT, 16'hFFFF);
        send_text("TWFu", 1'b0);
        drain();
        cfg_write(CFG_LIMIT, 16'd1);
        send_text("TW", 1'b1);
        drain();
    endtask

    task automatic random_run();
        int phase_no;
        phase_no   = 0;
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            tx_steady = ($urandom_range(0, 4) == 0);
            rx_steady = ($urandom_range(0, 4) == 0);
            set_mode(mode_t'($urandom_range(0, 1)));
            cfg_write(CFG_LIMIT, pick_limit());
            if (phase_no == 0) begin
                tx_steady = 1'b1;
                long_holds_wanted++;
            end
            repeat ($urandom_range(2, 6)) begin
                if (tb_mode == MODE_ENCODE) begin
                    random_encode_message();
                end else begin
                    random_decode_message();
                end
            end
            drain();
            phase_no++;
        end
    endtask

    initial begin
        aresetn           = 1'b0;
        cfg_valid         = 1'b0;
        cfg_index         = CFG_MODE;
        cfg_data          = '0;
        s_valid           = 1'b0;
        s_in_byte         = '0;
        s_in_last         = 1'b0;
        tb_mode           = MODE_ENCODE;
        tx_steady         = 1'b0;
        rx_steady         = 1'b0;
        long_holds_wanted = 0;
        items_sent        = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        directed_run();
        random_run();
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
